/* rtl/ifd_pkg.sv */
// Package for the incremental Frechet distance block: field widths, action codes,
// cell constants and the control struct shared by the store and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ifd_pkg;

  localparam int DEF_MAX_POINTS = 16;
  localparam int DEF_COORD_BITS = 12;

  localparam int ACT_W         = 2;
  localparam int SLOT_FIELD_W  = 4;
  localparam int COORD_FIELD_W = 12;
  localparam int PL_W          = 5;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 16;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd2;

  localparam logic [PL_W-1:0] PATH_LEN_RESET = 5'd16;

  localparam int CELL_W = 13;
  localparam logic [CELL_W-1:0] CELL_INF        = 13'h1FFF;
  localparam logic [CELL_W-1:0] CELL_MAX_FINITE = 13'h1FFE;

  // Squared distances at or above this value have a root beyond the largest finite cell.
  localparam logic [63:0] SAT_LIMIT = 64'd67092481;

  localparam int ROOT_STEPS = CELL_W;
  localparam int RAD_W      = 2 * CELL_W;
  localparam int REM_W      = CELL_W + 3;
  localparam int STEP_CNT_W = 4;

  typedef struct packed {
    logic ref_we;
    logic col_we;
    logic col_clear;
  } store_ctl_t;

endpackage

`default_nettype wire

/* rtl/ifd_dist_unit.sv */
// Iterative Euclidean distance unit: absolute differences, one shared squarer used
// twice, then a digit-by-digit square root giving one root bit per cycle. Uses ifd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifd_dist_unit
  import ifd_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [COORD_BITS-1:0] ax,
  input  wire logic [COORD_BITS-1:0] ay,
  input  wire logic [COORD_BITS-1:0] bx,
  input  wire logic [COORD_BITS-1:0] by,
  output logic                       done,
  output logic [CELL_W-1:0]          dist_value
);

  localparam int SQ_W = 2 * COORD_BITS + 1;

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_MULX = 3'd1;
  localparam logic [2:0] D_MULY = 3'd2;
  localparam logic [2:0] D_CHK  = 3'd3;
  localparam logic [2:0] D_SQRT = 3'd4;

  logic [2:0]              dstate;
  logic [COORD_BITS-1:0]   dx;
  logic [COORD_BITS-1:0]   dy;
  logic [SQ_W-1:0]         acc;
  logic [RAD_W-1:0]        rad;
  logic [REM_W-1:0]        rem;
  logic [CELL_W-1:0]       root;
  logic [STEP_CNT_W-1:0]   cnt;

  logic [COORD_BITS-1:0]   mul_op;
  logic [2*COORD_BITS-1:0] prod;
  logic [REM_W-1:0]        rem_sh;
  logic [REM_W-1:0]        trial;
  logic                    fits;
  logic [REM_W-1:0]        rem_next;
  logic [CELL_W-1:0]       root_next;

  assign mul_op = (dstate == D_MULX) ? dx : dy;
  assign prod   = mul_op * mul_op;

  assign rem_sh    = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial     = REM_W'({root, 2'b01});
  assign fits      = rem_sh >= trial;
  assign rem_next  = fits ? (rem_sh - trial) : rem_sh;
  assign root_next = {root[CELL_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            dstate <= D_MULX;
          end
        end
        D_MULX: begin
          dstate <= D_MULY;
        end
        D_MULY: begin
          dstate <= D_CHK;
        end
        D_CHK: begin
          if (64'(acc) >= SAT_LIMIT) begin
            done   <= 1'b1;
            dstate <= D_IDLE;
          end else begin
            dstate <= D_SQRT;
          end
        end
        D_SQRT: begin
          if (cnt == '0) begin
            done   <= 1'b1;
            dstate <= D_IDLE;
          end
        end
        default: begin
          dstate <= D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (dstate)
      D_IDLE: begin
        dx <= (ax >= bx) ? (ax - bx) : (bx - ax);
        dy <= (ay >= by) ? (ay - by) : (by - ay);
      end
      D_MULX: begin
        acc <= SQ_W'(prod);
      end
      D_MULY: begin
        acc <= acc + SQ_W'(prod);
      end
      D_CHK: begin
        rad        <= RAD_W'(acc);
        rem        <= '0;
        root       <= '0;
        cnt        <= STEP_CNT_W'(ROOT_STEPS - 1);
        dist_value <= CELL_MAX_FINITE;
      end
      D_SQRT: begin
        rad        <= {rad[RAD_W-3:0], 2'b00};
        rem        <= rem_next;
        root       <= root_next;
        cnt        <= cnt - 1'b1;
        dist_value <= root_next;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ifd_store.sv */
// Reference point memory and coupling column memory with per-entry valid bits;
// an entry that is not valid reads as the infinite cell. Uses ifd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifd_store
  import ifd_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire store_ctl_t                    ctl,
  input  wire logic [$clog2(MAX_POINTS)-1:0] ref_waddr,
  input  wire logic [COORD_BITS-1:0]         ref_wx,
  input  wire logic [COORD_BITS-1:0]         ref_wy,
  input  wire logic [$clog2(MAX_POINTS)-1:0] col_waddr,
  input  wire logic [CELL_W-1:0]             col_wdata,
  input  wire logic [$clog2(MAX_POINTS)-1:0] raddr,
  output logic [COORD_BITS-1:0]              rd_x,
  output logic [COORD_BITS-1:0]              rd_y,
  output logic [CELL_W-1:0]                  rd_cell
);

  logic [2*COORD_BITS-1:0] ref_mem [MAX_POINTS];
  logic [CELL_W-1:0]       col_mem [MAX_POINTS];
  logic [MAX_POINTS-1:0]   col_valid;
  logic [2*COORD_BITS-1:0] ref_q;
  logic [CELL_W-1:0]       col_q;
  logic                    valid_q;

  always_ff @(posedge clk) begin
    if (ctl.ref_we) begin
      ref_mem[ref_waddr] <= {ref_wy, ref_wx};
    end
    ref_q <= ref_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    col_q <= col_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.col_clear) begin
      col_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (ctl.col_we) begin
        col_valid[col_waddr] <= 1'b1;
      end
      valid_q <= col_valid[raddr];
    end
  end

  assign rd_x    = ref_q[COORD_BITS-1:0];
  assign rd_y    = ref_q[2*COORD_BITS-1:COORD_BITS];
  assign rd_cell = valid_q ? col_q : CELL_INF;

endmodule

`default_nettype wire

/* rtl/incremental_frechet_distance.sv */
// Top level of the incremental discrete Frechet distance block: stream ports,
// path length register and the sequencer that walks the reference points.
// Uses ifd_pkg, ifd_store and ifd_dist_unit.
//
//   Channel  Direction  Signals                      Contents
//   s_*      in         tvalid tready tdata tuser    tuser action; tdata slot, x, y
//   m_*      out        tvalid tready tdata tuser    tdata distance; tuser finite flag
//   cfg_*    in         valid ready data             path length register
//
// Load and start requests are taken while idle; a sample walks each reference
// point in use through the shared squarer and the one-bit-a-cycle square root,
// taking no request until done. Saturating distances skip the root, ending sooner.
// Reset clears the coupling column valid bits and the control state at once.
// A sample waits at its end while an earlier result has not been taken.
`timescale 1ns / 1ps
`default_nettype none

module incremental_frechet_distance
  import ifd_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // point_index, coord_x, coord_y, zero pad
  input  wire logic [ACT_W-1:0]      s_tuser,  // action
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,  // frechet_distance, zero pad
  output logic                       m_tuser,  // distance_finite
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [PL_W-1:0]       cfg_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_GO   = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]              state;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        last_idx;
  logic [PL_W-1:0]         path_length;
  logic                    first_pending;
  logic [COORD_BITS-1:0]   sx;
  logic [COORD_BITS-1:0]   sy;
  logic [CELL_W-1:0]       diag;
  logic [CELL_W-1:0]       above;
  logic [CELL_W-1:0]       old_cell;

  logic [SLOT_FIELD_W-1:0]  in_slot;
  logic [COORD_FIELD_W-1:0] in_x;
  logic [COORD_FIELD_W-1:0] in_y;
  logic                     in_acc;
  logic [IDX_W-1:0]         last_sel;

  store_ctl_t              ctl;
  logic [COORD_BITS-1:0]   rd_x;
  logic [COORD_BITS-1:0]   rd_y;
  logic [CELL_W-1:0]       rd_cell;
  logic                    dist_start;
  logic                    dist_done;
  logic [CELL_W-1:0]       dist_value;
  logic [CELL_W-1:0]       min_a;
  logic [CELL_W-1:0]       min_b;
  logic [CELL_W-1:0]       new_cell;
  logic                    out_free;

  assign in_slot = s_tdata[SLOT_FIELD_W-1:0];
  assign in_x    = s_tdata[SLOT_FIELD_W +: COORD_FIELD_W];
  assign in_y    = s_tdata[SLOT_FIELD_W + COORD_FIELD_W +: COORD_FIELD_W];

  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    if (path_length == '0) begin
      last_sel = '0;
    end else if (32'(path_length) > MAX_POINTS) begin
      last_sel = IDX_W'(MAX_POINTS - 1);
    end else begin
      last_sel = IDX_W'(path_length - 1'b1);
    end
  end

  assign min_a    = (old_cell < diag) ? old_cell : diag;
  assign min_b    = (min_a < above) ? min_a : above;
  assign new_cell = (min_b > dist_value) ? min_b : dist_value;

  always_comb begin
    ctl.ref_we    = in_acc && (s_tuser == ACT_LOAD) && (32'(in_slot) < MAX_POINTS);
    ctl.col_clear = in_acc && (s_tuser == ACT_START);
    ctl.col_we    = (state == S_WAIT) && dist_done;
  end

  assign dist_start = (state == S_GO);

  ifd_store #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .ref_waddr(IDX_W'(in_slot)),
    .ref_wx   (COORD_BITS'(in_x)),
    .ref_wy   (COORD_BITS'(in_y)),
    .col_waddr(idx),
    .col_wdata(new_cell),
    .raddr    (idx),
    .rd_x     (rd_x),
    .rd_y     (rd_y),
    .rd_cell  (rd_cell)
  );

  ifd_dist_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .start     (dist_start),
    .ax        (sx),
    .ay        (sy),
    .bx        (rd_x),
    .by        (rd_y),
    .done      (dist_done),
    .dist_value(dist_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      path_length   <= PATH_LEN_RESET;
      first_pending <= 1'b1;
      m_tvalid      <= 1'b0;
      idx           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        path_length <= cfg_data;
      end
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (s_tuser == ACT_START)) begin
            first_pending <= 1'b1;
          end
          if (in_acc && (s_tuser == ACT_SAMPLE)) begin
            first_pending <= 1'b0;
            idx           <= '0;
            state         <= S_READ;
          end
        end
        S_READ: begin
          state <= S_GO;
        end
        S_GO: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (dist_done) begin
            if (idx == last_idx) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (s_tuser == ACT_SAMPLE)) begin
      sx       <= COORD_BITS'(in_x);
      sy       <= COORD_BITS'(in_y);
      last_idx <= last_sel;
      diag     <= first_pending ? '0 : CELL_INF;
      above    <= CELL_INF;
    end
    if (state == S_GO) begin
      old_cell <= rd_cell;
    end
    if ((state == S_WAIT) && dist_done) begin
      diag  <= old_cell;
      above <= new_cell;
    end
    if ((state == S_DONE) && out_free) begin
      m_tdata <= OUT_DATA_W'(above);
      m_tuser <= (above != CELL_INF);
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (idx <= last_idx))
    else $error("sequencer index beyond the last reference point in use");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    dist_done |-> (state == S_WAIT))
    else $error("distance unit finished while the sequencer was not waiting");

  a_finite_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == (m_tdata[CELL_W-1:0] != CELL_INF)))
    else $error("finite flag disagrees with the distance");

  a_start_marks_first: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (s_tuser == ACT_START)) |=> first_pending)
    else $error("start request did not mark the next sample as the first");

endmodule

`default_nettype wire

/* bench/incremental_frechet_distance_tb.sv */
// Testbench for incremental_frechet_distance: streams load, start and sample requests,
// predicts each coupling distance with its own model and checks every result in order.
// Depends on ifd_pkg and the incremental_frechet_distance RTL.
`timescale 1ns / 1ps

module incremental_frechet_distance_tb
  import ifd_pkg::*;
;

  localparam int NPTS = DEF_MAX_POINTS;
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES = 2500;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic [COORD_FIELD_W-1:0] x;
    logic [COORD_FIELD_W-1:0] y;
  } request_t;

  typedef struct packed {
    logic [CELL_W-1:0] distance;
    logic              finite;
  } distance_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [ACT_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [PL_W-1:0]       cfg_data = '0;

  incremental_frechet_distance #(
    .MAX_POINTS(NPTS),
    .COORD_BITS(DEF_COORD_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predicted block state.
  logic [COORD_FIELD_W-1:0] path_x [NPTS];
  logic [COORD_FIELD_W-1:0] path_y [NPTS];
  logic [CELL_W-1:0]        column [NPTS];
  logic                     first_sample;
  logic [PL_W-1:0]          path_len;

  // Reference points as the generator has queued them, used to aim samples nearby.
  logic [COORD_FIELD_W-1:0] queued_x [NPTS];
  logic [COORD_FIELD_W-1:0] queued_y [NPTS];

  request_t  pending_requests [$];
  distance_t expected_distances [$];
  int        pushed_count = 0;
  int        accepted_count = 0;
  int        mismatch_count = 0;
  logic      hold_go = 1'b0;

  function automatic logic [CELL_W-1:0] point_span(logic [COORD_FIELD_W-1:0] ax,
                                                   logic [COORD_FIELD_W-1:0] ay,
                                                   logic [COORD_FIELD_W-1:0] bx,
                                                   logic [COORD_FIELD_W-1:0] by);
    int unsigned dx, dy, sq, root, trial;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    sq = dx * dx + dy * dy;
    root = 0;
    for (int b = CELL_W - 1; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    if (root > CELL_MAX_FINITE) root = CELL_MAX_FINITE;
    return root[CELL_W-1:0];
  endfunction

  function automatic logic [CELL_W-1:0] min3(logic [CELL_W-1:0] a, logic [CELL_W-1:0] b,
                                             logic [CELL_W-1:0] c);
    logic [CELL_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic void apply_request(request_t r);
    int n;
    logic [CELL_W-1:0] corner, above, old_val, cell_val, span;
    distance_t res;
    case (r.action)
      ACT_LOAD: begin
        path_x[r.slot] = r.x;
        path_y[r.slot] = r.y;
      end
      ACT_START: begin
        for (int i = 0; i < NPTS; i++) column[i] = CELL_INF;
        first_sample = 1'b1;
      end
      ACT_SAMPLE: begin
        n = path_len;
        if (n < 1) n = 1;
        if (n > NPTS) n = NPTS;
        corner = first_sample ? '0 : CELL_INF;
        above = CELL_INF;
        for (int i = 0; i < n; i++) begin
          old_val = column[i];
          span = point_span(r.x, r.y, path_x[i], path_y[i]);
          cell_val = min3(old_val, corner, above);
          if (span > cell_val) cell_val = span;
          column[i] = cell_val;
          corner = old_val;
          above = cell_val;
        end
        first_sample = 1'b0;
        res.distance = column[n-1];
        res.finite = (column[n-1] != CELL_INF);
        expected_distances = {expected_distances, res};
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, distance_t want, distance_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%s: expected distance %0d finite %0b, got distance %0d finite %0b",
               what, want.distance, want.finite, got.distance, got.finite);
  endfunction

  function automatic void push_request(logic [ACT_W-1:0] action, int slot, int x, int y);
    request_t r;
    r.action = action;
    r.slot = slot[SLOT_FIELD_W-1:0];
    r.x = x[COORD_FIELD_W-1:0];
    r.y = y[COORD_FIELD_W-1:0];
    if (action == ACT_LOAD) begin
      queued_x[r.slot] = r.x;
      queued_y[r.slot] = r.y;
    end
    pending_requests = {pending_requests, r};
    pushed_count++;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic void push_sample();
    int sel, j, x, y;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      x = $urandom_range(0, 1) ? 4095 : 0;
      y = $urandom_range(0, 1) ? 4095 : 0;
    end else if (sel <= 5) begin
      j = $urandom_range(0, NPTS - 1);
      x = int'(queued_x[j]) + int'($urandom_range(0, 80)) - 40;
      y = int'(queued_y[j]) + int'($urandom_range(0, 80)) - 40;
      if (x < 0) x = 0;
      if (x > 4095) x = 4095;
      if (y < 0) y = 0;
      if (y > 4095) y = 4095;
    end else begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
    end
    push_request(ACT_SAMPLE, $urandom_range(0, NPTS - 1), x, y);
  endfunction

  // Mostly whole gestures (a start and a run of samples), with loads, stray samples
  // and unused action codes mixed in.
  function automatic void queue_gestures(int target);
    int made, k, runs;
    made = 0;
    while (made < target) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        push_request(ACT_START, $urandom_range(0, NPTS - 1), rand_coord(), rand_coord());
        made++;
        runs = $urandom_range(1, 8);
        for (int i = 0; i < runs; i++) begin
          push_sample();
          made++;
        end
      end else if (k < 8) begin
        push_request(ACT_LOAD, $urandom_range(0, NPTS - 1), rand_coord(), rand_coord());
        made++;
      end else if (k == 8) begin
        push_request(ACT_NOP, $urandom_range(0, NPTS - 1), rand_coord(), rand_coord());
      end else begin
        runs = $urandom_range(1, 3);
        for (int i = 0; i < runs; i++) begin
          push_sample();
          made++;
        end
      end
    end
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_count != pushed_count || expected_distances.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_path_length(logic [PL_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    path_len = value;
    cfg_valid <= 1'b0;
  endtask

  // Sender: bursts of random length separated by random gaps.
  request_t in_flight;
  int       burst_left = 0;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        apply_request(in_flight);
        accepted_count++;
      end
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_flight = pending_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_DATA_W - SLOT_FIELD_W - 2 * COORD_FIELD_W){1'b0}},
                    in_flight.y, in_flight.x, in_flight.slot};
        s_tuser <= in_flight.action;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: alternating ready and stall stretches, plus one long hold-off on request.
  int   hold_left = 0;
  int   stretch_left = 0;
  logic hold_taken = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stretch_left > 0) begin
        stretch_left--;
      end else if (m_tready) begin
        m_tready <= 1'b0;
        stretch_left = $urandom_range(0, 10);
      end else begin
        m_tready <= 1'b1;
        stretch_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(0, 30);
      end
    end
  end

  always @(posedge clk) begin
    distance_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.distance = m_tdata[CELL_W-1:0];
      got.finite = m_tuser;
      if (expected_distances.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_distances.pop_front();
        if (got.distance !== want.distance || got.finite !== want.finite)
          note_mismatch("wrong result", want, got);
      end
    end
  end

  initial begin
    int path_settings [12];
    path_settings = '{1, 0, 31, 5, 17, 3, 2, 8, 4, 6, 16, 7};
    for (int i = 0; i < NPTS; i++) begin
      column[i] = CELL_INF;
      path_x[i] = '0;
      path_y[i] = '0;
    end
    first_sample = 1'b1;
    path_len = PATH_LEN_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Every slot is loaded before the first sample so no unwritten point is ever read.
    for (int i = 0; i < NPTS; i++)
      push_request(ACT_LOAD, i, i * 273, (i % 2) ? 4095 : 0);
    push_request(ACT_START, 0, 0, 0);
    push_request(ACT_SAMPLE, 0, 0, 0);
    push_request(ACT_SAMPLE, 15, 4095, 4095);
    push_request(ACT_SAMPLE, 7, 2048, 2048);
    push_request(ACT_NOP, 15, 4095, 4095);
    push_request(ACT_SAMPLE, 5, 5 * 273, 4095);
    push_request(ACT_START, 15, 4095, 4095);
    push_request(ACT_SAMPLE, 0, 4095, 0);
    push_request(ACT_SAMPLE, 0, 0, 4095);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      write_path_length(path_settings[p][PL_W-1:0]);
      queue_gestures((path_settings[p] == 0 || path_settings[p] < NPTS) ? 105 : 40);
      if (p == 3) hold_go = 1'b1;
      wait_idle();
    end

    if (mismatch_count == 0 && expected_distances.size() == 0) begin
      $display("incremental_frechet_distance: match");
    end else begin
      $display("incremental_frechet_distance: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("incremental_frechet_distance: mismatch");
    $finish;
  end

endmodule
